/* rtl/q2e_pkg.sv */
// shared constants and helpers for the quaternion to euler angle pipeline
// used by the top level, the cordic unit and the square-root unit
package q2e_pkg;

    localparam int CORDIC_STEPS = 20;
    localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
    localparam int SQRT_BITS    = 31;
    localparam int SQRT_LAT     = SQRT_BITS;
    localparam int ACC_W        = 25;
    localparam int ANG_W        = 16;
    localparam int ANG_Y_W      = 15;
    localparam int TERM_W       = 36;
    localparam int OPND_W       = 38;

    localparam logic signed [ACC_W-1:0] ACC_QUARTER = 25'sd2949120;
    localparam logic signed [ANG_W-1:0] ANG_LIMIT   = 16'sd23040;
    localparam logic signed [ANG_W-1:0] ANG_RIGHT   = 16'sd11520;

    typedef logic signed [ANG_W-1:0] t_angle;

    // atan(2^-i) in degrees * 2^15, rounded to nearest
    function automatic logic signed [ACC_W-1:0] arc_step(input int idx);
        logic signed [ACC_W-1:0] v;
        case (idx)
            0:  v = 25'sd1474560;
            1:  v = 25'sd870484;
            2:  v = 25'sd459940;
            3:  v = 25'sd233473;
            4:  v = 25'sd117189;
            5:  v = 25'sd58652;
            6:  v = 25'sd29333;
            7:  v = 25'sd14667;
            8:  v = 25'sd7334;
            9:  v = 25'sd3667;
            10: v = 25'sd1833;
            11: v = 25'sd917;
            12: v = 25'sd458;
            13: v = 25'sd229;
            14: v = 25'sd115;
            15: v = 25'sd57;
            16: v = 25'sd29;
            17: v = 25'sd14;
            18: v = 25'sd7;
            19: v = 25'sd4;
            default: v = 25'sd0;
        endcase
        return v;
    endfunction

endpackage

/* rtl/quaternion_to_euler_angles_top.sv */
// quaternion to x-y-z euler angles, top level with the full pipeline
// depends on q2e_pkg, q2e_cordic and q2e_isqrt
//
// usage
//   slave channel: one quaternion per beat, w, x, y, z packed from bit 0 up
//   master channel: one beat per quaternion with the three angles in
//   degrees * 128 in tdata and the gimbal-lock flag in tuser
//   pipeline from accepted input beat to output valid: input register,
//   products, matrix terms, square, one minus the square, 31 square-root
//   bit stages, 22 cordic stages and the output register
//   throughput: one beat per cycle unless stalled, set by the fully pipelined
//   square root and the three cordic units that each take one step per stage
//   reset: clears every valid bit; the payload registers keep stale data
//   stall: when the output beat is held by the receiver the whole pipeline
//   freezes and tready drops; no beat is lost or repeated, and bubbles
//   left by an idle sender travel through as invalid slots
module quaternion_to_euler_angles_top #(
    parameter int QUAT_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // quat_w, quat_x, quat_y, quat_z, zero fill to whole bytes
    input  logic [((4*QUAT_BITS+7)/8)*8-1:0]     i_s_axis_tdata,
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // angle_x_deg, angle_y_deg, angle_z_deg, one zero fill bit
    output logic [47:0]                          o_m_axis_tdata,
    // gimbal_lock
    output logic                                 o_m_axis_tuser
);

    localparam int QB   = QUAT_BITS;
    localparam int SH_R = (2 * QB > 32) ? 2 * QB - 32 : 0;
    localparam int SH_L = (2 * QB < 32) ? 32 - 2 * QB : 0;
    localparam int TW   = q2e_pkg::TERM_W;
    localparam int OW   = q2e_pkg::OPND_W;
    localparam int AW   = q2e_pkg::ANG_W;
    localparam int NB   = q2e_pkg::SQRT_BITS;
    localparam int DLY  = q2e_pkg::SQRT_LAT + 2;
    localparam int LAT  = 5 + q2e_pkg::SQRT_LAT + q2e_pkg::CORDIC_LAT + 1;

    localparam logic signed [TW-1:0] ONE_Q30 = TW'(1) <<< 30;

    // pipeline advance and valid chain
    logic           en;
    logic [LAT-1:0] r_vld;

    assign en              = !r_vld[LAT-1] || i_m_axis_tready;
    assign o_s_axis_tready = en;
    assign o_m_axis_tvalid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_s_axis_tvalid};
        end
    end

    // product of two inputs in q30, floor rounding
    function automatic logic signed [TW-1:0] mul_q30(input logic signed [QB-1:0] a,
                                                     input logic signed [QB-1:0] b);
        logic signed [2*QB-1:0] p;
        logic signed [63:0]     e;
        p = a * b;
        e = 64'(p);
        e = (e >>> SH_R) <<< SH_L;
        return e[TW-1:0];
    endfunction

    // stage 1: input register
    logic signed [QB-1:0] r_w, r_x, r_y, r_z;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_w <= i_s_axis_tdata[0*QB +: QB];
            r_x <= i_s_axis_tdata[1*QB +: QB];
            r_y <= i_s_axis_tdata[2*QB +: QB];
            r_z <= i_s_axis_tdata[3*QB +: QB];
        end
    end

    // stage 2: pairwise products
    logic signed [TW-1:0] r_wx, r_wy, r_wz, r_xx, r_xy, r_xz, r_yy, r_yz, r_zz;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_wx <= mul_q30(r_w, r_x);
            r_wy <= mul_q30(r_w, r_y);
            r_wz <= mul_q30(r_w, r_z);
            r_xx <= mul_q30(r_x, r_x);
            r_xy <= mul_q30(r_x, r_y);
            r_xz <= mul_q30(r_x, r_z);
            r_yy <= mul_q30(r_y, r_y);
            r_yz <= mul_q30(r_y, r_z);
            r_zz <= mul_q30(r_z, r_z);
        end
    end

    // stage 3: matrix terms, sine saturation, operand selection
    logic signed [TW-1:0] n_sine, n_xy, n_xx;
    logic                 n_lock;
    logic signed [31:0]   r_sine;
    logic                 r_lock;
    logic signed [TW-1:0] r_xop_y, r_xop_x, r_zop_y, r_zop_x;

    always_comb begin
        n_sine = (r_wy - r_xz) <<< 1;
        n_lock = 1'b0;
        if (n_sine >= ONE_Q30) begin
            n_sine = ONE_Q30;
            n_lock = 1'b1;
        end
        if (n_sine <= -ONE_Q30) begin
            n_sine = -ONE_Q30;
            n_lock = 1'b1;
        end
        if (n_lock) begin
            n_xy = -((r_yz - r_wx) <<< 1);
            n_xx = ONE_Q30 - ((r_xx + r_zz) <<< 1);
        end else begin
            n_xy = (r_yz + r_wx) <<< 1;
            n_xx = ONE_Q30 - ((r_xx + r_yy) <<< 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sine  <= n_sine[31:0];
            r_lock  <= n_lock;
            r_xop_y <= n_xy;
            r_xop_x <= n_xx;
            r_zop_y <= (r_xy + r_wz) <<< 1;
            r_zop_x <= ONE_Q30 - ((r_yy + r_zz) <<< 1);
        end
    end

    // x and z angles
    q2e_pkg::t_angle ang_x, ang_z, ang_y;

    q2e_cordic #(.W(OW)) u_cordic_x (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (OW'(r_xop_y)),
        .i_x     (OW'(r_xop_x)),
        .o_angle (ang_x)
    );

    q2e_cordic #(.W(OW)) u_cordic_z (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (OW'(r_zop_y)),
        .i_x     (OW'(r_zop_x)),
        .o_angle (ang_z)
    );

    // stages 4 and 5: square of the sine and 1 - s^2
    logic signed [63:0]   r_sq;
    logic [2*NB-2:0]      r_rad;
    logic [NB-1:0]        root;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq  <= r_sine * r_sine;
            r_rad <= ((2*NB-1)'(1) << (2*NB-2)) - r_sq[2*NB-2:0];
        end
    end

    q2e_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_v    (r_rad),
        .o_root (root)
    );

    // sine and lock ride along the square root
    logic [32:0] r_ds [0:DLY-1];

    for (genvar k = 0; k < DLY; k++) begin : g_ds
        always_ff @(posedge i_clk) begin
            if (en) begin
                if (k == 0) begin
                    r_ds[k] <= {r_lock, r_sine};
                end else begin
                    r_ds[k] <= r_ds[k == 0 ? 0 : k-1];
                end
            end
        end
    end

    logic signed [31:0] d_sine;
    assign d_sine = r_ds[DLY-1][31:0];

    q2e_cordic #(.W(OW)) u_cordic_y (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (OW'(d_sine)),
        .i_x     (OW'({1'b0, root})),
        .o_angle (ang_y)
    );

    // lock and sign ride along the y cordic
    logic [1:0] r_sd [0:q2e_pkg::CORDIC_LAT-1];

    for (genvar k = 0; k < q2e_pkg::CORDIC_LAT; k++) begin : g_sd
        always_ff @(posedge i_clk) begin
            if (en) begin
                if (k == 0) begin
                    r_sd[k] <= {r_ds[DLY-1][32], d_sine[31]};
                end else begin
                    r_sd[k] <= r_sd[k == 0 ? 0 : k-1];
                end
            end
        end
    end

    // x and z angles wait for the y branch
    logic [2*AW-1:0] r_dxz [0:DLY-1];

    for (genvar k = 0; k < DLY; k++) begin : g_dxz
        always_ff @(posedge i_clk) begin
            if (en) begin
                if (k == 0) begin
                    r_dxz[k] <= {ang_z, ang_x};
                end else begin
                    r_dxz[k] <= r_dxz[k == 0 ? 0 : k-1];
                end
            end
        end
    end

    // output register
    logic                              f_lock, f_neg;
    q2e_pkg::t_angle                   n_ang_y;
    logic signed [q2e_pkg::ANG_Y_W-1:0] r_out_y;
    q2e_pkg::t_angle                   r_out_x, r_out_z;
    logic                              r_out_lock;

    assign f_lock = r_sd[q2e_pkg::CORDIC_LAT-1][1];
    assign f_neg  = r_sd[q2e_pkg::CORDIC_LAT-1][0];

    always_comb begin
        if (f_lock) begin
            n_ang_y = f_neg ? -q2e_pkg::ANG_RIGHT : q2e_pkg::ANG_RIGHT;
        end else if (ang_y > q2e_pkg::ANG_RIGHT) begin
            n_ang_y = q2e_pkg::ANG_RIGHT;
        end else if (ang_y < -q2e_pkg::ANG_RIGHT) begin
            n_ang_y = -q2e_pkg::ANG_RIGHT;
        end else begin
            n_ang_y = ang_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_x    <= r_dxz[DLY-1][AW-1:0];
            r_out_y    <= n_ang_y[q2e_pkg::ANG_Y_W-1:0];
            r_out_z    <= f_lock ? '0 : r_dxz[DLY-1][2*AW-1:AW];
            r_out_lock <= f_lock;
        end
    end

    assign o_m_axis_tdata = {1'b0, r_out_z, r_out_y, r_out_x};
    assign o_m_axis_tuser = r_out_lock;

endmodule

/* rtl/q2e_cordic.sv */
// pipelined vectoring cordic: atan2(y, x) in degrees * 128, one stage per step
// depends on q2e_pkg for the arc table and angle limits
module q2e_cordic #(
    parameter int W = 38
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [W-1:0]  i_y,
    input  logic signed [W-1:0]  i_x,
    output q2e_pkg::t_angle      o_angle
);

    localparam int N  = q2e_pkg::CORDIC_STEPS;
    localparam int AW = q2e_pkg::ACC_W;

    logic signed [W-1:0]  n_px, n_py, r_px, r_py;
    logic signed [AW-1:0] n_pacc, r_pacc;
    logic                 r_pzero;

    logic signed [W-1:0]  r_x   [1:N];
    logic signed [W-1:0]  r_y   [1:N];
    logic signed [AW-1:0] r_acc [1:N];
    logic                 r_zero[1:N];

    // quarter-turn pre-rotation into the right half plane
    always_comb begin
        n_px   = i_x;
        n_py   = i_y;
        n_pacc = '0;
        if (i_x < 0) begin
            if (i_y >= 0) begin
                n_px   = i_y;
                n_py   = -i_x;
                n_pacc = q2e_pkg::ACC_QUARTER;
            end else begin
                n_px   = -i_y;
                n_py   = i_x;
                n_pacc = -q2e_pkg::ACC_QUARTER;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px    <= n_px;
            r_py    <= n_py;
            r_pacc  <= n_pacc;
            r_pzero <= (i_x == '0) && (i_y == '0);
        end
    end

    // one micro-rotation per stage
    for (genvar k = 0; k < N; k++) begin : g_step
        logic signed [W-1:0]  s_x, s_y, n_x, n_y;
        logic signed [AW-1:0] s_acc, n_acc;
        logic                 s_zero;
        if (k == 0) begin : g_first
            assign s_x = r_px;
            assign s_y = r_py;
            assign s_acc = r_pacc;
            assign s_zero = r_pzero;
        end else begin : g_next
            assign s_x = r_x[k];
            assign s_y = r_y[k];
            assign s_acc = r_acc[k];
            assign s_zero = r_zero[k];
        end
        always_comb begin
            if (s_y >= 0) begin
                n_x   = s_x + (s_y >>> k);
                n_y   = s_y - (s_x >>> k);
                n_acc = s_acc + q2e_pkg::arc_step(k);
            end else begin
                n_x   = s_x - (s_y >>> k);
                n_y   = s_y + (s_x >>> k);
                n_acc = s_acc - q2e_pkg::arc_step(k);
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k+1]    <= n_x;
                r_y[k+1]    <= n_y;
                r_acc[k+1]  <= n_acc;
                r_zero[k+1] <= s_zero;
            end
        end
    end

    // round to degrees * 128 and clamp; a zero input vector gives zero
    logic signed [AW-1:0] n_round;
    q2e_pkg::t_angle      n_angle, r_angle;

    always_comb begin
        n_round = (r_acc[N] + AW'(128)) >>> 8;
        if (r_zero[N]) begin
            n_angle = '0;
        end else if (n_round > AW'(q2e_pkg::ANG_LIMIT)) begin
            n_angle = q2e_pkg::ANG_LIMIT;
        end else if (n_round < -AW'(q2e_pkg::ANG_LIMIT)) begin
            n_angle = -q2e_pkg::ANG_LIMIT;
        end else begin
            n_angle = n_round[q2e_pkg::ANG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_angle <= n_angle;
        end
    end

    assign o_angle = r_angle;

endmodule

/* rtl/q2e_isqrt.sv */
// pipelined floor square root of a 61-bit value, one result bit per stage
// depends on q2e_pkg for the root width
module q2e_isqrt (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic [2*q2e_pkg::SQRT_BITS-2:0]   i_v,
    output logic [q2e_pkg::SQRT_BITS-1:0]     o_root
);

    localparam int NB = q2e_pkg::SQRT_BITS;
    localparam int VW = 2 * NB - 1;

    logic [VW-1:0] r_v [1:NB];
    logic [VW-1:0] r_r [1:NB];

    for (genvar k = 0; k < NB; k++) begin : g_bit
        localparam logic [VW-1:0] BIT = VW'(1) << (VW - 1 - 2 * k);
        logic [VW-1:0] s_v, s_r, n_v, n_r;
        logic [VW:0]   trial;
        if (k == 0) begin : g_first
            assign s_v = i_v;
            assign s_r = '0;
        end else begin : g_next
            assign s_v = r_v[k];
            assign s_r = r_r[k];
        end
        // restoring step: try r + bit against the remainder
        always_comb begin
            trial = {1'b0, s_r} + {1'b0, BIT};
            if ({1'b0, s_v} >= trial) begin
                n_v = s_v - trial[VW-1:0];
                n_r = (s_r >> 1) + BIT;
            end else begin
                n_v = s_v;
                n_r = s_r >> 1;
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_v[k+1] <= n_v;
                r_r[k+1] <= n_r;
            end
        end
    end

    assign o_root = r_r[NB][NB-1:0];

endmodule

/* rtl/q2e_checker.sv */
// port-level checks for the quaternion to euler angle block
// bound to quaternion_to_euler_angles_top
module q2e_port_checks (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [47:0] o_m_axis_tdata,
    input logic        o_m_axis_tuser
);

    logic signed [15:0] ax, az;
    logic signed [14:0] ay;

    assign ax = o_m_axis_tdata[15:0];
    assign ay = o_m_axis_tdata[30:16];
    assign az = o_m_axis_tdata[46:31];

    // held beat keeps its valid
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("output beat dropped under stall");

    // gimbal lock forces z to zero
    a_lock_z: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> az == 16'sd0)
        else $error("z angle not zero at gimbal lock");

    // gimbal lock puts y at a right angle
    a_lock_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |->
            (ay == 15'sd11520 || ay == -15'sd11520))
        else $error("y angle not at a right angle at gimbal lock");

    // angles stay in range
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ay <= 15'sd11520 && ay >= -15'sd11520 &&
            ax <= 16'sd23040 && ax >= -16'sd23040)
        else $error("angle out of range");

endmodule

bind quaternion_to_euler_angles_top q2e_port_checks u_q2e_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
